// ----- rtl/scfl_pkg.sv -----
package scfl_pkg;

  localparam int unsigned MaxBins      = 16;
  localparam int unsigned BlocksPerBin = 128;
  localparam int unsigned UnitsLimit   = 100;
  localparam int unsigned BinUnits     = (BlocksPerBin < UnitsLimit) ? BlocksPerBin : UnitsLimit;
  localparam int unsigned TotalBlocks  = MaxBins * BlocksPerBin;

  localparam int unsigned IdW   = $clog2(TotalBlocks);
  localparam int unsigned LinkW = IdW + 1;
  localparam int unsigned BinW  = (MaxBins > 1) ? $clog2(MaxBins) : 1;
  localparam int unsigned CntW  = $clog2(MaxBins + 1);
  localparam int unsigned UnitW = $clog2(BinUnits);

  localparam int unsigned SizeW  = 16;
  localparam int unsigned GrantW = 11;

  localparam logic [SizeW-1:0] MinSize   = SizeW'(4);
  localparam logic [SizeW-1:0] SizeAlign = SizeW'(3);

  localparam logic FuncAlloc = 1'b0;
  localparam logic FuncFree  = 1'b1;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StBadSize = 2'd1,
    StNoBin   = 2'd2,
    StNoSpace = 2'd3
  } status_e;

  typedef struct packed {
    logic             func;
    logic [SizeW-1:0] size_bytes;
    logic [10:0]      block_id;
  } in_t;

  typedef struct packed {
    logic [GrantW-1:0] granted_id;
    logic [1:0]        status;
    logic              created_bin;
  } out_t;

  function automatic logic size_ok(input logic [SizeW-1:0] s);
    return (s >= MinSize) && ((s & SizeAlign) == '0);
  endfunction

endpackage

// ----- rtl/size_class_free_list_allocator_top.sv -----
// Sequence: an allocate scans the bins from bin 0 to its match, then pops that bin's head; a
//   free links its block in at the match; a miss scans all bins in use; a bad size skips the scan.
// An allocate that creates a bin adds a link fill that writes 100 link memory entries.
// One item at a time: the bin scan shares one size comparator; the next item is taken the
//   cycle after the result is registered, also while that result waits in the output register.
// Reset (async, active low) empties the bin table; bin and link stores are written before use.
module size_class_free_list_allocator_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  scfl_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output scfl_pkg::out_t out_data_o
);

  localparam logic [2:0] SIdle   = 3'd0;
  localparam logic [2:0] SSearch = 3'd1;
  localparam logic [2:0] SPop    = 3'd2;
  localparam logic [2:0] SFill   = 3'd3;
  localparam logic [2:0] SDone   = 3'd4;

  localparam logic [scfl_pkg::LinkW-1:0] EndMark = {1'b1, {scfl_pkg::IdW{1'b0}}};

  logic [2:0] state_q, state_d;
  logic [scfl_pkg::CntW-1:0] idx_q, idx_d, bins_q, bins_d;
  logic [scfl_pkg::UnitW-1:0] fill_q, fill_d;
  logic [scfl_pkg::IdW-1:0] fill_addr_q, fill_addr_d;
  scfl_pkg::in_t req_q, req_d;
  scfl_pkg::out_t res_q, res_d, out_q, out_d;
  logic out_valid_q, out_valid_d;

  logic [scfl_pkg::SizeW-1:0] bin_size_q [scfl_pkg::MaxBins];
  logic [scfl_pkg::LinkW-1:0] bin_head_q [scfl_pkg::MaxBins];
  logic [scfl_pkg::LinkW-1:0] link_mem [scfl_pkg::TotalBlocks];
  logic [scfl_pkg::LinkW-1:0] link_rdata_q;

  logic head_we, size_we, link_we;
  logic [scfl_pkg::BinW-1:0] head_widx;
  logic [scfl_pkg::LinkW-1:0] head_wdata, link_wdata;
  logic [scfl_pkg::IdW-1:0] link_waddr, link_raddr, new_base;

  logic [scfl_pkg::BinW-1:0] cur_bin, new_bin;
  logic [scfl_pkg::SizeW-1:0] cur_size;
  logic [scfl_pkg::LinkW-1:0] cur_head;
  logic at_end, hit, fill_last;

  assign cur_bin    = idx_q[scfl_pkg::BinW-1:0];
  assign new_bin    = bins_q[scfl_pkg::BinW-1:0];
  assign cur_size   = bin_size_q[cur_bin];
  assign cur_head   = bin_head_q[cur_bin];
  assign at_end     = (idx_q == bins_q);
  assign hit        = !at_end && (cur_size == req_q.size_bytes) &&
                      ((req_q.func == scfl_pkg::FuncFree) || !cur_head[scfl_pkg::LinkW-1]);
  assign link_raddr = cur_head[scfl_pkg::IdW-1:0];
  assign new_base   = scfl_pkg::IdW'(bins_q * scfl_pkg::BlocksPerBin);
  assign fill_last  = (fill_q == scfl_pkg::UnitW'(scfl_pkg::BinUnits - 1));

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    bins_d      = bins_q;
    fill_d      = fill_q;
    fill_addr_d = fill_addr_q;
    req_d       = req_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    head_we     = 1'b0;
    head_widx   = cur_bin;
    head_wdata  = link_rdata_q;
    size_we     = 1'b0;
    link_we     = 1'b0;
    link_waddr  = fill_addr_q;
    link_wdata  = cur_head;

    case (state_q)
      SIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          req_d = in_data_i;
          idx_d = '0;
          res_d = '0;
          if (!scfl_pkg::size_ok(in_data_i.size_bytes)) begin
            res_d.status = scfl_pkg::StBadSize;
            state_d      = SDone;
          end else begin
            state_d = SSearch;
          end
        end
      end
      SSearch: begin
        if (hit) begin
          if (req_q.func == scfl_pkg::FuncAlloc) begin
            res_d.granted_id = scfl_pkg::GrantW'(cur_head[scfl_pkg::IdW-1:0]);
            state_d          = SPop;
          end else begin
            if (scfl_pkg::LinkW'(req_q.block_id) < scfl_pkg::LinkW'(scfl_pkg::TotalBlocks)) begin
              link_we    = 1'b1;
              link_waddr = scfl_pkg::IdW'(req_q.block_id);
              link_wdata = cur_head;
              head_we    = 1'b1;
              head_wdata = scfl_pkg::LinkW'(req_q.block_id);
            end
            state_d = SDone;
          end
        end else if (at_end) begin
          if (req_q.func == scfl_pkg::FuncFree) begin
            res_d.status = scfl_pkg::StNoBin;
            state_d      = SDone;
          end else if (bins_q == scfl_pkg::CntW'(scfl_pkg::MaxBins)) begin
            res_d.status = scfl_pkg::StNoSpace;
            state_d      = SDone;
          end else begin
            fill_d      = '0;
            fill_addr_d = new_base;
            state_d     = SFill;
          end
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      SPop: begin
        head_we = 1'b1;
        state_d = SDone;
      end
      SFill: begin
        link_we     = 1'b1;
        link_wdata  = fill_last ? EndMark : scfl_pkg::LinkW'(fill_addr_q + 1'b1);
        fill_d      = fill_q + 1'b1;
        fill_addr_d = fill_addr_q + 1'b1;
        if (fill_last) begin
          // creation pops the first slot, so the head moves to the second
          head_we           = 1'b1;
          head_widx         = new_bin;
          head_wdata        = scfl_pkg::LinkW'(new_base + 1'b1);
          size_we           = 1'b1;
          bins_d            = bins_q + 1'b1;
          res_d.granted_id  = scfl_pkg::GrantW'(new_base);
          res_d.created_bin = 1'b1;
          state_d           = SDone;
        end
      end
      SDone: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      bins_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bins_q      <= bins_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    fill_q      <= fill_d;
    fill_addr_q <= fill_addr_d;
    req_q       <= req_d;
    res_q       <= res_d;
    out_q       <= out_d;
    if (head_we) begin
      bin_head_q[head_widx] <= head_wdata;
    end
    if (size_we) begin
      bin_size_q[new_bin] <= req_q.size_bytes;
    end
  end

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    link_rdata_q <= link_mem[link_raddr];
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_bins_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bins_q <= scfl_pkg::CntW'(scfl_pkg::MaxBins))
    else $error("bin count beyond table size");

  a_bins_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bins_q != $past(bins_q)) |-> (bins_q == $past(bins_q) + 1'b1) && ($past(state_q) == SFill))
    else $error("bin count changed outside bin creation");

  a_created_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.created_bin |-> out_data_o.status == scfl_pkg::StOk)
    else $error("bin created with error status");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != scfl_pkg::StOk) |-> out_data_o.granted_id == '0)
    else $error("nonzero id with error status");

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SFill) |=> !in_ready_o || (state_q == SIdle))
    else $error("input taken during link fill");

endmodule
